### design/tab_expander_core_macros.svh
// ----------------------------------------------------------------------------
// tab_expander_core_macros
// Assertion helpers used by the tab expander top level.
// ----------------------------------------------------------------------------
`ifndef TAB_EXPANDER_CORE_MACROS_SVH
`define TAB_EXPANDER_CORE_MACROS_SVH

// clocked assertion, not masked by reset
`define TEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// clocked assertion, masked while reset is held
`define TEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

### design/tec_pkg.sv
// ----------------------------------------------------------------------------
// tec_pkg
// Shared types, widths and symbol codes of the tab expander.
// ----------------------------------------------------------------------------
package tec_pkg;

  // payload widths
  localparam int SYM_W      = 21;
  localparam int CNT_W      = 12;
  localparam int STOP_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int SCNT_W     = 3;

  // parameter defaults
  localparam int MAX_STOPS_DEF   = 6;
  localparam int COLUMN_BITS_DEF = 12;
  localparam int QUEUE_DEPTH_DEF = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ONLY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT   = 3'd1;
  localparam int                   REG_STOP_BASE    = 2;

  // register reset values
  localparam logic [STOP_W-1:0] STOP0_RST = 12'd8;
  localparam logic [STOP_W-1:0] STOPN_RST = 12'd4095;
  localparam logic [SCNT_W-1:0] SCNT_RST  = 3'd1;

  // control code points
  localparam logic [SYM_W-1:0] SYM_BS  = 21'd8;
  localparam logic [SYM_W-1:0] SYM_TAB = 21'd9;
  localparam logic [SYM_W-1:0] SYM_NL  = 21'd10;
  localparam logic [SYM_W-1:0] SYM_SP  = 21'd32;

  // symbol class decided by the front end
  typedef enum logic [2:0] {
    KIND_OTHER,
    KIND_TAB,
    KIND_BS,
    KIND_NL,
    KIND_SP
  } kind_e;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    kind_e            kind;
  } item_t;

endpackage

### design/tec_front.sv
// ----------------------------------------------------------------------------
// tec_front
// Input stage: takes a symbol beat, classifies it and holds it for the queue.
// ----------------------------------------------------------------------------
module tec_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [tec_pkg::SYM_W-1:0] in_symbol_i,
  output logic                      fe_valid_o,
  input  logic                      fe_ready_i,
  output tec_pkg::item_t            fe_item_o
);
  import tec_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  item_t item_cls;
  logic  take;

  // classify the incoming code point
  always_comb begin
    item_cls.symbol = in_symbol_i;
    case (in_symbol_i)
      SYM_TAB: item_cls.kind = KIND_TAB;
      SYM_BS:  item_cls.kind = KIND_BS;
      SYM_NL:  item_cls.kind = KIND_NL;
      SYM_SP:  item_cls.kind = KIND_SP;
      default: item_cls.kind = KIND_OTHER;
    endcase
  end

  // one-entry stage, refilled as it drains
  assign in_ready_o = !valid_q || fe_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign valid_d    = take || (valid_q && !fe_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_cls;
    end
  end

  assign fe_valid_o = valid_q;
  assign fe_item_o  = item_q;

endmodule

### design/tec_queue.sv
// ----------------------------------------------------------------------------
// tec_queue
// Short FIFO of classified symbols between the front and back ends.
// ----------------------------------------------------------------------------
module tec_queue #(
  parameter int DEPTH = tec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  tec_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output tec_pkg::item_t pop_item_o
);
  import tec_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] CNT_FULL = CNT_W_Q'(DEPTH);

  item_t               mem_q [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W_Q-1:0]  count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != CNT_FULL);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W_Q'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W_Q'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### design/tec_back.sv
// ----------------------------------------------------------------------------
// tec_back
// Execution end: holds configuration, column and line state, works out tab
// distances with a bit-serial remainder unit or a stop-by-stop search, and
// drives the result register.
// ----------------------------------------------------------------------------
module tec_back #(
  parameter int MAX_STOPS   = tec_pkg::MAX_STOPS_DEF,
  parameter int COLUMN_BITS = tec_pkg::COLUMN_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [tec_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tec_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           q_valid_i,
  output logic                           q_ready_o,
  input  tec_pkg::item_t                 q_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tec_pkg::SYM_W-1:0]      out_symbol_o,
  output logic [tec_pkg::CNT_W-1:0]      repeat_count_o
);
  import tec_pkg::*;

  localparam int WW     = (COLUMN_BITS > STOP_W) ? COLUMN_BITS : STOP_W;
  localparam int BIT_W  = $clog2(COLUMN_BITS);
  localparam int SIDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SRCH = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // saturating column advance
  function automatic logic [COLUMN_BITS-1:0] col_add(
    input logic [COLUMN_BITS-1:0] c,
    input logic [STOP_W-1:0]      d
  );
    logic [WW:0] s;
    s = (WW+1)'(c) + (WW+1)'(d);
    if (s > (WW+1)'(COL_MAX)) begin
      col_add = COL_MAX;
    end else begin
      col_add = s[COLUMN_BITS-1:0];
    end
  endfunction

  // configuration registers
  logic                initial_only_q;
  logic [SCNT_W-1:0]   stop_count_q;
  logic [STOP_W-1:0]   stops_q [MAX_STOPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_only_q <= 1'b0;
      stop_count_q   <= SCNT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_INITIAL_ONLY) begin
        initial_only_q <= cfg_data_i[0];
      end
      if (cfg_index_i == REG_STOP_COUNT) begin
        stop_count_q <= cfg_data_i[SCNT_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < MAX_STOPS; k++) begin : g_stop
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stops_q[k] <= (k == 0) ? STOP0_RST : STOPN_RST;
      end else if (cfg_valid_i && (cfg_index_i == CFG_IDX_W'(REG_STOP_BASE + k))) begin
        stops_q[k] <= cfg_data_i[STOP_W-1:0];
      end
    end
  end

  // working state
  logic [1:0]             state_q, state_d;
  logic [COLUMN_BITS-1:0] column_q, column_d;
  logic                   line_start_q, line_start_d;
  logic [COLUMN_BITS-1:0] col_sh_q, col_sh_d;
  logic [STOP_W-1:0]      rem_q, rem_d;
  logic [BIT_W-1:0]       bit_cnt_q, bit_cnt_d;
  logic [SIDX_W-1:0]      sidx_q, sidx_d;
  logic [STOP_W-1:0]      dist_q, dist_d;
  logic                   out_valid_q, out_valid_d;
  logic [SYM_W-1:0]       out_sym_q, out_sym_d;
  logic [CNT_W-1:0]       out_cnt_q, out_cnt_d;

  // effective stop count and interval
  logic [SCNT_W-1:0] n_eff;
  logic              interval_mode;
  logic [STOP_W-1:0] iv;

  always_comb begin
    if (stop_count_q == '0) begin
      n_eff = SCNT_W'(1);
    end else if (stop_count_q > SCNT_W'(MAX_STOPS)) begin
      n_eff = SCNT_W'(MAX_STOPS);
    end else begin
      n_eff = stop_count_q;
    end
  end

  assign interval_mode = (n_eff == SCNT_W'(1));
  assign iv            = (stops_q[0] == '0) ? STOP_W'(1) : stops_q[0];

  // one remainder bit per cycle
  logic [STOP_W:0]   div_t;
  logic [STOP_W:0]   div_sub;
  logic [STOP_W-1:0] rem_nx;

  always_comb begin
    div_t   = {rem_q, col_sh_q[COLUMN_BITS-1]};
    div_sub = div_t - {1'b0, iv};
    rem_nx  = (div_t >= {1'b0, iv}) ? div_sub[STOP_W-1:0] : div_t[STOP_W-1:0];
  end

  // one listed stop compared per cycle
  logic [STOP_W-1:0] cur_stop;
  logic              stop_hit;
  logic              stop_last;
  logic [WW-1:0]     stop_diff;
  logic [SCNT_W-1:0] sidx_ext;

  always_comb begin
    cur_stop  = stops_q[sidx_q];
    stop_hit  = WW'(column_q) < WW'(cur_stop);
    stop_diff = WW'(cur_stop) - WW'(column_q);
    sidx_ext  = SCNT_W'(sidx_q);
    stop_last = (sidx_ext == n_eff - SCNT_W'(1));
  end

  // handshake on both sides
  logic slot_free;
  logic expand;

  assign slot_free = !out_valid_q || out_ready_i;
  assign expand    = line_start_q || !initial_only_q;
  assign q_ready_o = (state_q == ST_IDLE) && ((q_item_i.kind == KIND_TAB) || slot_free);

  // sequencer
  always_comb begin
    state_d      = state_q;
    column_d     = column_q;
    line_start_d = line_start_q;
    col_sh_d     = col_sh_q;
    rem_d        = rem_q;
    bit_cnt_d    = bit_cnt_q;
    sidx_d       = sidx_q;
    dist_d       = dist_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sym_d    = out_sym_q;
    out_cnt_d    = out_cnt_q;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && q_ready_o) begin
          case (q_item_i.kind)
            KIND_TAB: begin
              if (interval_mode) begin
                col_sh_d  = column_q;
                rem_d     = '0;
                bit_cnt_d = BIT_W'(COLUMN_BITS - 1);
                state_d   = ST_DIV;
              end else begin
                sidx_d  = '0;
                state_d = ST_SRCH;
              end
            end
            KIND_BS: begin
              line_start_d = 1'b0;
              if (column_q != '0) begin
                column_d = column_q - COLUMN_BITS'(1);
              end
              out_valid_d = 1'b1;
              out_sym_d   = q_item_i.symbol;
              out_cnt_d   = CNT_W'(1);
            end
            KIND_NL: begin
              line_start_d = 1'b1;
              column_d     = '0;
              out_valid_d  = 1'b1;
              out_sym_d    = q_item_i.symbol;
              out_cnt_d    = CNT_W'(1);
            end
            KIND_SP: begin
              column_d    = col_add(column_q, STOP_W'(1));
              out_valid_d = 1'b1;
              out_sym_d   = q_item_i.symbol;
              out_cnt_d   = CNT_W'(1);
            end
            default: begin
              line_start_d = 1'b0;
              column_d     = col_add(column_q, STOP_W'(1));
              out_valid_d  = 1'b1;
              out_sym_d    = q_item_i.symbol;
              out_cnt_d    = CNT_W'(1);
            end
          endcase
        end
      end
      ST_DIV: begin
        col_sh_d = col_sh_q << 1;
        rem_d    = rem_nx;
        if (bit_cnt_q == '0) begin
          dist_d  = iv - rem_nx;
          state_d = ST_FIN;
        end else begin
          bit_cnt_d = bit_cnt_q - BIT_W'(1);
        end
      end
      ST_SRCH: begin
        if (stop_hit) begin
          dist_d  = stop_diff[STOP_W-1:0];
          state_d = ST_FIN;
        end else if (stop_last) begin
          dist_d  = STOP_W'(1);
          state_d = ST_FIN;
        end else begin
          sidx_d = sidx_q + SIDX_W'(1);
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          column_d    = col_add(column_q, dist_q);
          out_valid_d = 1'b1;
          out_sym_d   = expand ? SYM_SP : SYM_TAB;
          out_cnt_d   = expand ? CNT_W'(dist_q) : CNT_W'(1);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      column_q     <= '0;
      line_start_q <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      column_q     <= column_d;
      line_start_q <= line_start_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    col_sh_q  <= col_sh_d;
    rem_q     <= rem_d;
    bit_cnt_q <= bit_cnt_d;
    sidx_q    <= sidx_d;
    dist_q    <= dist_d;
    out_sym_q <= out_sym_d;
    out_cnt_q <= out_cnt_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_symbol_o   = out_sym_q;
  assign repeat_count_o = out_cnt_q;

endmodule

### design/tab_expander_core.sv
// ----------------------------------------------------------------------------
// tab_expander_core
// Expands tabs in a stream of code points into (symbol, repeat count) beats.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat. Ordinary symbols, spaces,
// backspaces and newlines are taken in the back end's idle state, so a run
// of them flows at one beat per cycle while the output is taken. A tab with
// a single repeating stop goes through a remainder state and a finish state:
// the column is reduced modulo the interval by a remainder unit that settles
// one bit per cycle. A tab with a list of stops goes through a search state
// that compares the stops in use one per cycle until the next stop is found.
// A front stage and a short queue take new beats while a tab is worked out,
// and the result register lets one beat wait at the output. Configuration
// writes are taken in any cycle but must only be issued while the block is
// idle; there is no clearing pass after reset.
`include "tab_expander_core_macros.svh"

module tab_expander_core #(
  parameter int MAX_STOPS   = tec_pkg::MAX_STOPS_DEF,
  parameter int COLUMN_BITS = tec_pkg::COLUMN_BITS_DEF,
  parameter int QUEUE_DEPTH = tec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tec_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tec_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tec_pkg::SYM_W-1:0]      in_symbol_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tec_pkg::SYM_W-1:0]      out_symbol_o,
  output logic [tec_pkg::CNT_W-1:0]      repeat_count_o
);
  import tec_pkg::*;

  logic  fe_valid, fe_ready;
  item_t fe_item;
  logic  bq_valid, bq_ready;
  item_t bq_item;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  // front end
  tec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_symbol_i (in_symbol_i),
    .fe_valid_o  (fe_valid),
    .fe_ready_i  (fe_ready),
    .fe_item_o   (fe_item)
  );

  // decoupling queue
  tec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_item_i  (fe_item),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_item_o   (bq_item)
  );

  // back end
  tec_back #(
    .MAX_STOPS   (MAX_STOPS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .q_valid_i      (bq_valid),
    .q_ready_o      (bq_ready),
    .q_item_i       (bq_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_symbol_o   (out_symbol_o),
    .repeat_count_o (repeat_count_o)
  );

  // checks
  `TEC_ASSERT(a_count_nonzero, out_valid_o |-> (repeat_count_o != '0), "zero repeat count")
  `TEC_ASSERT(a_single_unless_space, (out_valid_o && (out_symbol_o != SYM_SP)) |-> (repeat_count_o == CNT_W'(1)), "repeated non-space symbol")
  `TEC_ASSERT(a_front_holds, (fe_valid && !fe_ready) |=> (fe_valid && $stable(fe_item)), "front beat lost while queue full")

endmodule
